[rtl/core/assert_macros.svh]
// Assertion macros shared by the queue RTL; they use the clk_i and rst_ni ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/fqs_pkg.sv]
// Package with the constants, codes and types of the searchable queue.
package fqs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } fqs_mem_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic [CNT_W-1:0]         position;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] front_value;
    logic                     front_valid;
  } fqs_result_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

[rtl/core/fqs_mem.sv]
// Entry store of the queue: one write port and one registered read port.
module fqs_mem (
  input  logic                             clk_i,
  input  fqs_pkg::fqs_mem_req_t            req_i,
  output logic [fqs_pkg::DATA_W-1:0]       rdata_o
);
  import fqs_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read happens before the write of the same edge lands.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fqs_seq.sv]
// Sequencer of the queue: pointers, count and the shared compare that walks a search.
module fqs_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           busy_o,
  input  logic [1:0]                     operation_i,
  input  logic signed [fqs_pkg::DATA_W-1:0] value_i,
  output fqs_pkg::fqs_mem_req_t          mem_req_o,
  input  logic [fqs_pkg::DATA_W-1:0]     mem_rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output fqs_pkg::fqs_result_t           res_o
);
  import fqs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POPRD = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [PTR_W-1:0]         rd_q, rd_d;
  logic [PTR_W-1:0]         wr_q, wr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [1:0]               status_q, status_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic [PTR_W-1:0]         scan_q, scan_d;
  logic [CNT_W-1:0]         issue_q, issue_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic                     hit;

  assign hit = (mem_rdata_i == val_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    popped_d  = popped_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    issue_d   = issue_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wr_q;
    mem_req_o.wdata = value_i;
    // The read port follows the front except while a search walks the entries.
    mem_req_o.raddr = (state_q == S_SCAN) ? scan_q : rd_q;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = operation_i;
          val_d     = value_i;
          popped_d  = '0;
          pos_d     = '0;
          status_d  = ST_OK;
          cmp_vld_d = 1'b0;
          state_d   = S_FRONT;
          unique case (operation_i)
            OP_PUSH: begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_req_o.we = 1'b1;
                wr_d  = next_slot(wr_q);
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (cnt_q == '0) status_d = ST_EMPTY;
              else state_d = S_POPRD;
            end
            OP_SEARCH: begin
              status_d = ST_NOTFOUND;
              if (cnt_q != '0) begin
                scan_d  = rd_q;
                issue_d = '0;
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: begin
              rd_d  = '0;
              wr_d  = '0;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_POPRD: begin
        popped_d = mem_rdata_i;
        rd_d     = next_slot(rd_q);
        cnt_d    = cnt_q - CNT_W'(1);
        state_d  = S_FRONT;
      end
      S_SCAN: begin
        // One read is issued per cycle; the word read last cycle is compared now.
        if (issue_q != cnt_q) begin
          scan_d    = next_slot(scan_q);
          issue_d   = issue_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (hit) begin
            pos_d    = cmp_idx_q + CNT_W'(1);
            status_d = ST_OK;
            state_d  = S_FRONT;
          end else if (cmp_idx_q + CNT_W'(1) == cnt_q) begin
            state_d = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      wr_q      <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    status_q  <= status_d;
    popped_q  <= popped_d;
    pos_q     <= pos_d;
    scan_q    <= scan_d;
    issue_q   <= issue_d;
    cmp_idx_q <= cmp_idx_d;
  end

  assign busy_o = (state_q != S_IDLE);

  assign res_o.status       = status_q;
  assign res_o.popped_value = popped_q;
  assign res_o.position     = pos_q;
  assign res_o.count        = cnt_q;
  assign res_o.front_valid  = (cnt_q != '0);
  assign res_o.front_value  = (cnt_q != '0) ? signed'(mem_rdata_i) : '0;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_IMPLIES(a_ptr_match, (cnt_q == '0) || (cnt_q == CNT_W'(DEPTH)), rd_q == wr_q, "pointers differ on empty or full queue")
  `ASSERT_IMPLIES(a_hit_pos, res_valid_o && op_q == OP_SEARCH && status_q == ST_OK, pos_q != '0 && pos_q <= cnt_q, "search hit outside held entries")

endmodule

[rtl/core/fifo_queue_with_search.sv]
// Top level of the searchable queue: sequencer, entry store and output register.
//
//  channel | direction | handshake               | words
//  in      | into      | in_valid_i / in_stall_o | operation_i, value_i
//  out     | out of    | out_valid_o/out_stall_i | status, popped, position, count, front
//
// A push or clear word passes the sequencer states S_FRONT and S_OUT into the output register;
// a pop on a non-empty queue first passes S_POPRD, and a search on one first walks S_SCAN.
// The search time is set by the single read port of the entry store, walked one entry a cycle.
// Reset clears pointers, count and the output valid flag; stored words are not cleared.
// The next input word can be taken in the cycle after the previous result has moved into the
// output register, so a stalled output register stalls the input as well.
module fifo_queue_with_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [fqs_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [fqs_pkg::DATA_W-1:0] popped_value_o,
  output logic [fqs_pkg::CNT_W-1:0]         position_o,
  output logic [fqs_pkg::CNT_W-1:0]         count_o,
  output logic signed [fqs_pkg::DATA_W-1:0] front_value_o,
  output logic                              front_valid_o
);
  import fqs_pkg::*;

  fqs_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  fqs_result_t       res;
  fqs_result_t       res_q;
  logic              out_valid_q, out_valid_d;
  logic              busy;

  fqs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_o      (busy),
    .operation_i (operation_i),
    .value_i     (value_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  fqs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) res_q <= res;
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign popped_value_o = res_q.popped_value;
  assign position_o     = res_q.position;
  assign count_o        = res_q.count;
  assign front_value_o  = res_q.front_value;
  assign front_valid_o  = res_q.front_valid;

  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_front_flag, out_valid_o, front_valid_o == (count_o != '0), "bad front flag")

endmodule

[dv/tb_fifo_queue_with_search.sv]
// Self-checking testbench for the searchable queue: random and directed words against a predictor.
module tb_fifo_queue_with_search;
  import fqs_pkg::*;

  localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_NEG1 = -32'sd1;
  localparam int                       RANDOM_CMDS = 700;
  localparam int                       TAIL_CMDS   = 60;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] word;
    bit                       drain_pause;
  } queue_cmd_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 operation_i = OP_PUSH;
  logic signed [DATA_W-1:0]   value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 status_o;
  logic signed [DATA_W-1:0]   popped_value_o;
  logic [CNT_W-1:0]           position_o;
  logic [CNT_W-1:0]           count_o;
  logic signed [DATA_W-1:0]   front_value_o;
  logic                       front_valid_o;

  queue_cmd_t  cmd_backlog[$];
  fqs_result_t due_results[$];

  // Predictor state: a copy of the queue contents and its pointers.
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  logic [PTR_W-1:0]         shadow_rd = '0;
  logic [PTR_W-1:0]         shadow_wr = '0;
  logic [CNT_W-1:0]         shadow_held = '0;

  int n_cmds = 0;
  int n_fail = 0;
  int n_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int drv_gap_left = 0;
  int drv_odds = 6;
  int mon_stall_left = 0;
  int mon_odds = 6;

  fifo_queue_with_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .position_o    (position_o),
    .count_o       (count_o),
    .front_value_o (front_value_o),
    .front_valid_o (front_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("fifo_queue_with_search test failed");
    $finish;
  end

  // Applies one operation to the shadow queue and returns the result it must produce.
  function automatic fqs_result_t next_queue_result(input logic [1:0] op,
                                                    input logic signed [DATA_W-1:0] word);
    fqs_result_t r;
    int          slot;
    bit          hit;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_held == CNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_wr] = word;
          shadow_wr = (shadow_wr == PTR_W'(DEPTH - 1)) ? '0 : shadow_wr + 1'b1;
          shadow_held = shadow_held + 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_held == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_words[shadow_rd];
          shadow_rd = (shadow_rd == PTR_W'(DEPTH - 1)) ? '0 : shadow_rd + 1'b1;
          shadow_held = shadow_held - 1'b1;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        hit = 1'b0;
        for (int i = 0; i < int'(shadow_held); i++) begin
          slot = (int'(shadow_rd) + i) % DEPTH;
          if (!hit && shadow_words[slot] == word) begin
            hit = 1'b1;
            r.position = CNT_W'(i + 1);
            r.status = ST_OK;
          end
        end
      end
      default: begin
        shadow_rd = '0;
        shadow_wr = '0;
        shadow_held = '0;
      end
    endcase
    r.count = shadow_held;
    r.front_valid = (shadow_held != '0);
    r.front_value = (shadow_held != '0) ? shadow_words[shadow_rd] : '0;
    return r;
  endfunction

  // Mostly a narrow range, so that searches hit and duplicates occur.
  function automatic logic signed [DATA_W-1:0] rand_word();
    logic signed [DATA_W-1:0] w;
    case ($urandom_range(0, 9))
      0, 1:    w = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0:       w = WORD_MIN;
          1:       w = WORD_MAX;
          2:       w = WORD_NEG1;
          3:       w = 32'sd1;
          default: w = '0;
        endcase
      end
      default: w = $signed(32'($urandom_range(0, 7))) - 32'sd4;
    endcase
    return w;
  endfunction

  task automatic add_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] word);
    queue_cmd_t c;
    c.op = op;
    c.word = word;
    c.drain_pause = 1'b0;
    cmd_backlog.push_back(c);
    n_cmds++;
  endtask

  task automatic add_drain_pause();
    queue_cmd_t c;
    c.op = OP_PUSH;
    c.word = '0;
    c.drain_pause = 1'b1;
    cmd_backlog.push_back(c);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Sender: takes commands from the backlog and holds each word until it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    queue_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= OP_PUSH;
      value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(next_queue_result(operation_i, value_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap_left > 0) begin
          drv_gap_left--;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (cmd_backlog[0].drain_pause) begin
          // Hold off until the block has returned every outstanding result.
          in_valid_i <= 1'b0;
          if (due_results.size() == 0) begin
            void'(cmd_backlog.pop_front());
          end
        end else if (cmd_backlog.size() > TAIL_CMDS && $urandom_range(0, drv_odds) == 0) begin
          drv_gap_left = $urandom_range(1, 16) - 1;
          drv_odds = ($urandom_range(0, 2) == 0) ? 2 : ($urandom_range(0, 1) ? 6 : 40);
          in_valid_i <= 1'b0;
        end else begin
          c = cmd_backlog.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= c.op;
          value_i <= c.word;
        end
      end
    end
  end

  // Receiver: checks each accepted result word and stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    fqs_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        status_seen[status_o]++;
        if (due_results.size() == 0) begin
          $error("result word with no operation outstanding");
          n_fail++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          check_field("status", want.status, status_o);
          check_field("popped_value", want.popped_value, popped_value_o);
          check_field("position", want.position, position_o);
          check_field("count", want.count, count_o);
          check_field("front_value", want.front_value, front_value_o);
          check_field("front_valid", want.front_valid, front_valid_o);
        end
      end
      if (mon_stall_left > 0) begin
        mon_stall_left--;
        out_stall_i <= 1'b1;
      end else if (cmd_backlog.size() > TAIL_CMDS && $urandom_range(0, mon_odds) == 0) begin
        mon_stall_left = $urandom_range(1, 16) - 1;
        mon_odds = ($urandom_range(0, 2) == 0) ? 2 : ($urandom_range(0, 1) ? 6 : 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int                       len;
    int                       pick;
    logic signed [DATA_W-1:0] base;

    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Directed: empty-queue cases, extreme words, first match, clear.
    add_cmd(OP_POP, '0);
    add_cmd(OP_SEARCH, '0);
    add_cmd(OP_PUSH, WORD_MIN);
    add_cmd(OP_PUSH, WORD_MAX);
    add_cmd(OP_PUSH, WORD_NEG1);
    add_cmd(OP_PUSH, '0);
    add_cmd(OP_SEARCH, WORD_MIN);
    add_cmd(OP_SEARCH, '0);
    add_cmd(OP_SEARCH, 32'sd1);
    add_cmd(OP_POP, '0);
    add_cmd(OP_SEARCH, WORD_NEG1);
    add_cmd(OP_CLEAR, WORD_MAX);
    add_cmd(OP_POP, '0);
    add_cmd(OP_SEARCH, WORD_NEG1);
    add_cmd(OP_PUSH, 32'sh5A5A_A5A5);
    add_cmd(OP_POP, '0);
    add_drain_pause();

    while (n_cmds < RANDOM_CMDS + 16) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 20);
          repeat (len) add_cmd(OP_PUSH, rand_word());
        end
        3, 4: begin
          len = $urandom_range(1, 20);
          repeat (len) add_cmd(OP_POP, rand_word());
        end
        5, 6: begin
          len = $urandom_range(1, 12);
          repeat (len) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)       add_cmd(OP_PUSH, rand_word());
            else if (pick < 13) add_cmd(OP_POP, rand_word());
            else if (pick < 19) add_cmd(OP_SEARCH, rand_word());
            else                add_cmd(OP_CLEAR, rand_word());
          end
        end
        7: begin
          len = $urandom_range(1, 6);
          repeat (len) add_cmd(OP_SEARCH, rand_word());
        end
        8: begin
          // Distinct words fill the queue, so a search can match the very last entry.
          base = $urandom;
          add_cmd(OP_CLEAR, rand_word());
          for (int i = 0; i < DEPTH; i++) add_cmd(OP_PUSH, base + i);
          add_cmd(OP_PUSH, rand_word());
          add_cmd(OP_SEARCH, base + DEPTH - 1);
          add_cmd(OP_SEARCH, base + $urandom_range(0, DEPTH - 1));
        end
        default: begin
          len = $urandom_range(1, 8);
          repeat (len) add_cmd(2'($urandom_range(0, 3)), $urandom);
        end
      endcase
      if ($urandom_range(0, 14) == 0) add_drain_pause();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d operations sent, %0d results checked", n_cmds, n_checked);
    $display("statuses seen: %0d ok, %0d pop on empty, %0d push dropped, %0d not found",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND]);
    if (n_fail == 0 && due_results.size() == 0) begin
      $display("fifo_queue_with_search test passed");
    end else begin
      $display("fifo_queue_with_search test failed");
    end
    $finish;
  end

endmodule
